// File: rtl/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// mmcs_pkg : shared types and constants of the contrast stretch
// Holds the job control word passed from the front end to the divider,
// the queue geometry and the fixed gray scale constants.
// ----------------------------------------------------------------------------
package mmcs_pkg;

  // gray scale
  localparam int          GRAY_BITS = 8;
  localparam logic [7:0]  GRAY_ZERO = 8'd0;
  localparam logic [7:0]  GRAY_FULL = 8'd255;

  // command codes
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  // job queue between front end and divider
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // how the back end must finish a convert job
  typedef struct packed {
    logic divide;    // run the divider on numerator / spread
    logic sat_full;  // no division: 255 if set, else 0
  } job_ctl_t;

  localparam int JOB_CTL_BITS = $bits(job_ctl_t);

endpackage

// File: rtl/mmcs_front.sv
// ----------------------------------------------------------------------------
// mmcs_front : transaction acceptance, min/max tracking and job setup
// Measure transactions update the running minimum and maximum. Convert
// transactions are classified against the current range and, where a
// division is needed, turned into numerator 255*(p-min) and the spread.
// ----------------------------------------------------------------------------
module mmcs_front #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_command,
  input  logic signed [PIXEL_BITS-1:0] in_pixel,
  input  logic                         in_first_of_area,
  // job queue write side
  input  logic                         q_full,
  output logic                         q_push,
  output mmcs_pkg::job_ctl_t           q_ctl,
  output logic [PIXEL_BITS+7:0]        q_num,
  output logic [PIXEL_BITS-1:0]        q_den
);

  localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
  localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

  logic signed [PIXEL_BITS-1:0] min_r, min_nxt;
  logic signed [PIXEL_BITS-1:0] max_r, max_nxt;
  logic                         accept;
  logic                         spread_pos, p_le_min, p_ge_max;
  logic [PIXEL_BITS-1:0]        diff_w, spread_w;
  logic [PIXEL_BITS+7:0]        diff_x;

  // every transaction, measure included, is refused while the queue is full
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // running range update
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (accept && (in_command == mmcs_pkg::CMD_MEASURE)) begin
      if (in_first_of_area) begin
        min_nxt = in_pixel;
        max_nxt = in_pixel;
      end else begin
        if (in_pixel < min_r) min_nxt = in_pixel;
        if (in_pixel > max_r) max_nxt = in_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= PIX_MAX;
      max_r <= PIX_MIN;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  // classify the pixel against the range seen so far
  assign spread_pos = max_r > min_r;
  assign p_le_min   = in_pixel <= min_r;
  assign p_ge_max   = in_pixel >= max_r;

  // both differences are positive when a division is run, so they fit unsigned
  assign diff_w   = in_pixel - min_r;
  assign spread_w = max_r - min_r;
  assign diff_x   = {8'd0, diff_w};

  // only convert transactions leave a job behind
  assign q_push          = accept && (in_command == mmcs_pkg::CMD_CONVERT);
  assign q_ctl.divide    = spread_pos && !p_le_min && !p_ge_max;
  assign q_ctl.sat_full  = spread_pos && !p_le_min && p_ge_max;
  assign q_num           = (diff_x << 8) - diff_x;   // 255 * (p - min)
  assign q_den           = spread_w;

endmodule

// File: rtl/mmcs_queue.sv
// ----------------------------------------------------------------------------
// mmcs_queue : short job queue between front end and divider
// Plain register FIFO; lets the front end keep taking transactions while
// the divider is busy.
// ----------------------------------------------------------------------------
module mmcs_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0]              mem [mmcs_pkg::QUEUE_DEPTH];
  logic [mmcs_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [mmcs_pkg::QUEUE_AW:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full    = count_r == (mmcs_pkg::QUEUE_AW+1)'(mmcs_pkg::QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/mmcs_back.sv
// ----------------------------------------------------------------------------
// mmcs_back : restoring divider and result register
// Takes one job at a time, produces the 8-bit quotient one bit a cycle and
// holds it in an output register until the consumer pops it.
// ----------------------------------------------------------------------------
module mmcs_back #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // job queue read side
  input  logic                  q_empty,
  output logic                  q_pop,
  input  mmcs_pkg::job_ctl_t    q_ctl,
  input  logic [PIXEL_BITS+7:0] q_num,
  input  logic [PIXEL_BITS-1:0] q_den,
  // result channel
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [7:0]            out_gray
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  logic [PIXEL_BITS+7:0] rem_r, rem_nxt;
  logic [PIXEL_BITS+7:0] dsh_r, dsh_nxt;
  logic [7:0]            quo_r, quo_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [7:0]            gray_r, gray_nxt;
  logic                  slot_free, ge;

  assign slot_free = !ovalid_r || out_pop;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign ge        = rem_r >= dsh_r;
  assign out_empty = !ovalid_r;
  assign out_gray  = gray_r;

  // sequencer and divider step
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    dsh_nxt    = dsh_r;
    quo_nxt    = quo_r;
    ovalid_nxt = ovalid_r && !out_pop;
    gray_nxt   = gray_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_ctl.divide) begin
            rem_nxt   = q_num;
            dsh_nxt   = {8'd0, q_den} << 7;
            quo_nxt   = '0;
            cnt_nxt   = 3'd7;
            state_nxt = ST_DIV;
          end else begin
            quo_nxt   = q_ctl.sat_full ? mmcs_pkg::GRAY_FULL : mmcs_pkg::GRAY_ZERO;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (ge) rem_nxt = rem_r - dsh_r;
        quo_nxt = {quo_r[6:0], ge};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          gray_nxt   = quo_r;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
    gray_r <= gray_nxt;
  end

endmodule

// File: rtl/min_max_contrast_stretch.sv
// ----------------------------------------------------------------------------
// min_max_contrast_stretch : min-max contrast stretch to 8-bit gray
// Measure transactions track the area's minimum and maximum; convert
// transactions map a pixel to floor(255*(p-min)/(max-min)), saturated.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------
//   input    | in_push/in_full  | in_command, in_pixel, in_first_of_area
//   result   | out_pop/out_empty| out_gray
//
// A convert transaction is queued and finished by the shared restoring
// divider: a load step, eight quotient steps and a transfer into the output
// register; a saturated or flat-range pixel skips the quotient steps.
// rst_n is synchronous: it clears the range to its empty state and empties
// the queue. in_full rises when the four-entry job queue is full; the output
// register holds a result until out_pop, stalling the divider behind it.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_command,
  input  logic signed [PIXEL_BITS-1:0] in_pixel,
  input  logic                         in_first_of_area,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [7:0]                   out_gray
);

  localparam int JOB_BITS = mmcs_pkg::JOB_CTL_BITS + 2*PIXEL_BITS + 8;

  logic                  wq_push, wq_full, rq_pop, rq_empty;
  mmcs_pkg::job_ctl_t    wq_ctl, rq_ctl;
  logic [PIXEL_BITS+7:0] wq_num, rq_num;
  logic [PIXEL_BITS-1:0] wq_den, rq_den;
  logic [JOB_BITS-1:0]   rq_data;

  mmcs_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_pixel         (in_pixel),
    .in_first_of_area (in_first_of_area),
    .q_full           (wq_full),
    .q_push           (wq_push),
    .q_ctl            (wq_ctl),
    .q_num            (wq_num),
    .q_den            (wq_den)
  );

  mmcs_queue #(.WIDTH(JOB_BITS)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (wq_push),
    .wr_data ({wq_ctl, wq_num, wq_den}),
    .full    (wq_full),
    .pop     (rq_pop),
    .rd_data (rq_data),
    .empty   (rq_empty)
  );

  assign rq_ctl = rq_data[JOB_BITS-1 -: mmcs_pkg::JOB_CTL_BITS];
  assign rq_num = rq_data[PIXEL_BITS +: PIXEL_BITS+8];
  assign rq_den = rq_data[PIXEL_BITS-1:0];

  mmcs_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (rq_empty),
    .q_pop     (rq_pop),
    .q_ctl     (rq_ctl),
    .q_num     (rq_num),
    .q_den     (rq_den),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_gray  (out_gray)
  );

endmodule
